[sv/afs_pkg.sv]
// ---------------------------------------------------------------------------
// afs_pkg - shared types and constants for actuator feedback selection
// Field widths, selector and register codes, reset values and the lane
// result record passed from the conversion lanes to the output merge.
// ---------------------------------------------------------------------------
package afs_pkg;

  // sample and coefficient widths
  localparam int SAMPLE_BITS = 10;
  localparam int SCALE_W     = 17;
  localparam int BIAS_W      = 13;
  localparam int POS_W       = 15;
  localparam int NUM_AXES    = 4;
  localparam int AXIS_W      = 2;

  // scale is 2^-20 deg/count, result is 2^-10 deg
  localparam int FRAC_SHIFT  = 10;
  localparam int ROUND_HALF  = 512;
  localparam int PROD_W      = SAMPLE_BITS + SCALE_W;
  // product dominates the bias term for any SAMPLE_BITS >= 8
  localparam int SUM_W       = PROD_W + 1;
  localparam int Q_W         = SUM_W - FRAC_SHIFT;
  localparam int POS_MAX     = 16383;
  localparam int POS_MIN     = -16384;

  // input stream layout: eight samples, two selectors, faults, full flag
  localparam int SEL_L_LSB   = 8 * SAMPLE_BITS;
  localparam int SEL_R_LSB   = SEL_L_LSB + 2;
  localparam int FAULT_LSB   = SEL_R_LSB + 2;
  localparam int FULL_BIT    = FAULT_LSB + 4;
  localparam int IN_BITS     = FULL_BIT + 1;
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

  // output stream layout
  localparam int OUT_BITS    = 3 * POS_W + 1;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W  = AXIS_W + 1;

  // link fault bits
  localparam int FLT_L_ACT   = 0;
  localparam int FLT_L_STB   = 1;
  localparam int FLT_R_STB   = 2;
  localparam int FLT_R_ACT   = 3;

  // channel selector codes
  localparam logic [1:0] SEL_ACTIVE  = 2'd0;
  localparam logic [1:0] SEL_STANDBY = 2'd1;
  localparam logic [1:0] SEL_CHECK   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_L_PITCH_SCALE = 3'd0;
  localparam logic [2:0] REG_L_YAW_SCALE   = 3'd1;
  localparam logic [2:0] REG_R_PITCH_SCALE = 3'd2;
  localparam logic [2:0] REG_R_YAW_SCALE   = 3'd3;
  localparam logic [2:0] REG_L_PITCH_BIAS  = 3'd4;
  localparam logic [2:0] REG_L_YAW_BIAS    = 3'd5;
  localparam logic [2:0] REG_R_PITCH_BIAS  = 3'd6;
  localparam logic [2:0] REG_R_YAW_BIAS    = 3'd7;

  // reset values
  localparam logic signed [SCALE_W-1:0] RST_L_PITCH_SCALE = 17'sd17196;
  localparam logic signed [SCALE_W-1:0] RST_L_YAW_SCALE   = 17'sd17155;
  localparam logic signed [SCALE_W-1:0] RST_R_PITCH_SCALE = 17'sd17196;
  localparam logic signed [SCALE_W-1:0] RST_R_YAW_SCALE   = -17'sd17155;
  localparam logic signed [BIAS_W-1:0]  RST_L_PITCH_BIAS  = 13'sd75;
  localparam logic signed [BIAS_W-1:0]  RST_L_YAW_BIAS    = 13'sd435;
  localparam logic signed [BIAS_W-1:0]  RST_R_PITCH_BIAS  = 13'sd75;
  localparam logic signed [BIAS_W-1:0]  RST_R_YAW_BIAS    = -13'sd435;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t active_pos;
    pos_t standby_pos;
    pos_t selected;
    logic good;
  } afs_res_t;

endpackage

[sv/afs_lane.sv]
// ---------------------------------------------------------------------------
// afs_lane - one axis: convert active/standby samples and pick a channel
// Multiply on load, then round, saturate and select on advance. Holds the
// selected position and data-good flag for its axis.
// ---------------------------------------------------------------------------
module afs_lane import afs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          advance,
  input  logic signed [SAMPLE_BITS-1:0] active_raw,
  input  logic signed [SAMPLE_BITS-1:0] standby_raw,
  input  logic signed [SCALE_W-1:0]     scale,
  input  logic signed [BIAS_W-1:0]      bias,
  input  logic [1:0]                    sel,
  input  logic                          act_fault,
  input  logic                          stb_fault,
  output afs_res_t                      res
);

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_s;
  logic [1:0]               sel_r;
  logic                     af_r;
  logic                     sf_r;
  pos_t                     held_sel;
  logic                     held_good;
  pos_t                     pos_a;
  pos_t                     pos_s;
  pos_t                     held_sel_next;
  logic                     held_good_next;

  function automatic pos_t to_pos(input logic signed [PROD_W-1:0] prod,
                                  input logic signed [BIAS_W-1:0] b);
    logic signed [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]   q;
    sum = SUM_W'(prod) + (SUM_W'(b) <<< FRAC_SHIFT) + SUM_W'(ROUND_HALF);
    q   = $signed(sum[SUM_W-1:FRAC_SHIFT]);   // floor
    if (q > Q_W'(POS_MAX)) begin
      to_pos = POS_W'(POS_MAX);
    end else if (q < Q_W'(POS_MIN)) begin
      to_pos = POS_W'(POS_MIN);
    end else begin
      to_pos = q[POS_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= PROD_W'(active_raw) * PROD_W'(scale);
      prod_s <= PROD_W'(standby_raw) * PROD_W'(scale);
      sel_r  <= sel;
      af_r   <= act_fault;
      sf_r   <= stb_fault;
    end
  end

  assign pos_a = to_pos(prod_a, bias);
  assign pos_s = to_pos(prod_s, bias);

  always_comb begin
    held_sel_next  = held_sel;
    held_good_next = held_good;
    case (sel_r)
      SEL_CHECK: begin
        if (!af_r && !sf_r) begin
          held_good_next = 1'b1;
        end
      end
      default: begin
        // standby code and the unused code both fall back to standby
        if (sel_r == SEL_ACTIVE && !af_r) begin
          held_sel_next  = pos_a;
          held_good_next = 1'b1;
        end else if (!sf_r) begin
          held_sel_next  = pos_s;
          held_good_next = 1'b1;
        end else begin
          held_good_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sel  <= '0;
      held_good <= 1'b0;
    end else if (advance) begin
      held_sel  <= held_sel_next;
      held_good <= held_good_next;
    end
  end

  assign res.active_pos  = pos_a;
  assign res.standby_pos = pos_s;
  assign res.selected    = held_sel_next;
  assign res.good        = held_good_next;

  // both channels faulted under a switching selector drops the good flag
  a_both_faulted: assert property (@(posedge clk) disable iff (rst)
    advance && sel_r != SEL_CHECK && af_r && sf_r |=> !held_good)
    else $error("lane kept data-good with both channels faulted");

endmodule

[sv/afs_merge.sv]
// ---------------------------------------------------------------------------
// afs_merge - gathers the four lane results and sends them one per request
// Four-entry result buffer with an axis counter; reloads when empty or as
// the last axis of the previous frame leaves.
// ---------------------------------------------------------------------------
module afs_merge import afs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  afs_res_t              lane_res [NUM_AXES],
  input  logic                  full,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AXIS_W-1:0]     out_axis,
  output afs_res_t              out_res,
  output logic                  out_full,
  output logic                  out_last
);

  afs_res_t          buf_res [NUM_AXES];
  logic              full_r;
  logic [AXIS_W-1:0] idx;
  logic              valid;
  logic              take;
  logic              at_last;

  assign take     = valid && out_ready;
  assign at_last  = (idx == AXIS_W'(NUM_AXES - 1));
  assign can_load = !valid || (take && at_last);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        buf_res[i].active_pos  <= full ? lane_res[i].active_pos  : '0;
        buf_res[i].standby_pos <= full ? lane_res[i].standby_pos : '0;
        buf_res[i].selected    <= lane_res[i].selected;
        buf_res[i].good        <= lane_res[i].good;
      end
      full_r <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid <= 1'b0;
      end
      idx <= idx + AXIS_W'(1);
    end
  end

  assign out_valid = valid;
  assign out_axis  = idx;
  assign out_res   = buf_res[idx];
  assign out_full  = full_r;
  assign out_last  = at_last;

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> valid && idx == '0)
    else $error("frame load did not restart at first axis");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready && !load |=> valid && $stable(idx))
    else $error("axis counter moved while stalled");

  a_step: assert property (@(posedge clk) disable iff (rst)
    take && !at_last |=> valid && idx == $past(idx) + AXIS_W'(1))
    else $error("axis counter skipped or dropped a result");

endmodule

[sv/actuator_feedback_select.sv]
// ---------------------------------------------------------------------------
// actuator_feedback_select - actuator position conversion and channel pick
// Four parallel axis lanes scale, offset and saturate the active and
// standby samples, choose a channel per axis and keep held position and
// data-good state; a merge stage sends four axis results per frame.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: 8 samples, selects, faults, full
// m_*       out  m_tvalid/m_tready  m_tdata: positions, good; m_tuser: axis,
//                                   reported; m_tlast: last axis
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// The single result channel carries one axis result per cycle while m_tready
// is high. The first result shows in the cycle after the frame is taken from
// the product stage into the merge buffer; an input request is first
// registered in the product stage.
// Reset clears held positions and flags and restores default coefficients.
// A stalled output holds the buffer; one more frame waits in the product
// stage, and s_tready drops only when both are occupied.
// ---------------------------------------------------------------------------
module actuator_feedback_select import afs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // request in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [SAMPLE_BITS*k +: SAMPLE_BITS] samples k=0..7: left act pitch, left act
  // yaw, left stb pitch, left stb yaw, right act pitch, right act yaw,
  // right stb pitch, right stb yaw; then left_select[2], right_select[2],
  // link_faults[4], full_report[1], zero fill
  input  logic [IN_W-1:0]        s_tdata,
  // result out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // active_position[15], standby_position[15], selected_position[15],
  // data_good[1], zero fill
  output logic [OUT_W-1:0]       m_tdata,
  // axis[2], positions_reported[1]
  output logic [OUT_USER_W-1:0]  m_tuser,
  output logic                   m_tlast,   // last_axis
  // configuration
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_addr,
  input  logic [SCALE_W-1:0]     cfg_wdata
);

  logic signed [SCALE_W-1:0] scale [NUM_AXES];
  logic signed [BIAS_W-1:0]  bias  [NUM_AXES];

  logic      s_take;      // input request accepted
  logic      b_valid;     // product stage occupied
  logic      b_full;      // full_report of that frame
  logic      can_load;
  logic      advance;     // product stage moves into merge buffer
  afs_res_t  lane_res [NUM_AXES];
  afs_res_t  out_res;
  logic [AXIS_W-1:0] out_axis;
  logic      out_full;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0] <= RST_L_PITCH_SCALE;
      scale[1] <= RST_L_YAW_SCALE;
      scale[2] <= RST_R_PITCH_SCALE;
      scale[3] <= RST_R_YAW_SCALE;
      bias[0]  <= RST_L_PITCH_BIAS;
      bias[1]  <= RST_L_YAW_BIAS;
      bias[2]  <= RST_R_PITCH_BIAS;
      bias[3]  <= RST_R_YAW_BIAS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_L_PITCH_SCALE: scale[0] <= cfg_wdata;
        REG_L_YAW_SCALE:   scale[1] <= cfg_wdata;
        REG_R_PITCH_SCALE: scale[2] <= cfg_wdata;
        REG_R_YAW_SCALE:   scale[3] <= cfg_wdata;
        REG_L_PITCH_BIAS:  bias[0]  <= cfg_wdata[BIAS_W-1:0];
        REG_L_YAW_BIAS:    bias[1]  <= cfg_wdata[BIAS_W-1:0];
        REG_R_PITCH_BIAS:  bias[2]  <= cfg_wdata[BIAS_W-1:0];
        REG_R_YAW_BIAS:    bias[3]  <= cfg_wdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // product stage control
  assign advance  = b_valid && can_load;
  assign s_tready = !b_valid || advance;
  assign s_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_take) begin
      b_valid <= 1'b1;
    end else if (advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      b_full <= s_tdata[FULL_BIT];
    end
  end

  // one lane per axis; left axes use left selector and left fault bits
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
    localparam int ACT_K = (ax < 2) ? ax : ax + 2;
    localparam int STB_K = ACT_K + 2;
    localparam int SEL_LSB = (ax < 2) ? SEL_L_LSB : SEL_R_LSB;
    localparam int AF_BIT  = FAULT_LSB + ((ax < 2) ? FLT_L_ACT : FLT_R_ACT);
    localparam int SF_BIT  = FAULT_LSB + ((ax < 2) ? FLT_L_STB : FLT_R_STB);

    afs_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .load        (s_take),
      .advance     (advance),
      .active_raw  ($signed(s_tdata[SAMPLE_BITS*ACT_K +: SAMPLE_BITS])),
      .standby_raw ($signed(s_tdata[SAMPLE_BITS*STB_K +: SAMPLE_BITS])),
      .scale       (scale[ax]),
      .bias        (bias[ax]),
      .sel         (s_tdata[SEL_LSB +: 2]),
      .act_fault   (s_tdata[AF_BIT]),
      .stb_fault   (s_tdata[SF_BIT]),
      .res         (lane_res[ax])
    );
  end

  afs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .lane_res  (lane_res),
    .full      (b_full),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_axis  (out_axis),
    .out_res   (out_res),
    .out_full  (out_full),
    .out_last  (m_tlast)
  );

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), out_res.good, out_res.selected,
                    out_res.standby_pos, out_res.active_pos};
  assign m_tuser = {out_full, out_axis};

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    s_take |=> b_valid)
    else $error("accepted frame lost before product stage");

endmodule
